// ===== rtl/esdc_pkg.sv =====
// Shared widths, calendar constants, result types and month table of the epoch converter.
`default_nettype none

package esdc_pkg;

  localparam int unsigned SEC_W    = 39;
  localparam int unsigned YEAR_W   = 14;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MINUTE_W = 6;
  localparam int unsigned SECOND_W = 6;

  // Register stages inside each conversion unit; both units share it.
  localparam int unsigned PIPE_DEPTH = 11;
  // Register stages of the date-to-seconds arithmetic before its padding.
  localparam int unsigned D2S_DEPTH  = 7;

  // Seconds of 0000-01-01 00:00:00 .. 9999-12-31 23:59:59 bounds.
  localparam logic signed [SEC_W-1:0] SEC_MIN = -39'sd62167219200;
  localparam logic signed [SEC_W-1:0] SEC_MAX = 39'sd253402300799;

  localparam logic [YEAR_W-1:0] YEAR_MAX  = 14'd9999;
  localparam logic [17:0]       ERA_DAYS  = 18'd146097;
  // Day offset from 1970-01-01 to 0000-03-01, plus one era to keep days positive.
  localparam logic [19:0]       DAYS_BIAS = 20'd865565;

  typedef struct packed {
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
  } civil_t;

  typedef struct packed {
    civil_t civil;
    logic   range_error;
  } s2d_res_t;

  typedef struct packed {
    logic [SEC_W-1:0] seconds;
    logic             range_error;
  } d2s_res_t;

  // Day of year (counted from March 1) at which month index mp starts.
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] r;
    unique case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/esdc_s2d.sv =====
// Seconds-to-civil-date pipeline: floor day split, time of day, era method.
`default_nettype none

module esdc_s2d (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [esdc_pkg::SEC_W-1:0]   seconds,
  output esdc_pkg::s2d_res_t                  res
);

  // floor(x/675) for 33-bit x: estimate is exact or one low.
  localparam logic [31:0] RECIP_675  = 32'd3257812230;
  localparam logic [33:0] DIV_BIAS   = 34'd2831155200;   // 675 * 2^22
  localparam logic [22:0] Z_OFFSET   = 23'd3328739;      // 2^22 - DAYS_BIAS
  localparam logic [18:0] RECIP_60   = 19'd279621;       // exact for x < 86400, >> 24
  localparam logic [10:0] RECIP_60S  = 11'd1093;         // exact for x < 1440, >> 16
  localparam logic [14:0] RECIP_ERA  = 15'd29397;        // era estimate, >> 32
  localparam logic [15:0] RECIP_365  = 16'd45965;        // exact for x < 2^18, >> 24
  localparam logic [12:0] RECIP_153  = 13'd6854;         // exact for x < 1832, >> 20

  typedef struct packed {
    logic [esdc_pkg::HOUR_W-1:0]   hour;
    logic [esdc_pkg::MINUTE_W-1:0] minute;
    logic [esdc_pkg::SECOND_W-1:0] second;
    logic                          range_error;
  } tod_t;

  // Stage 1: split off seconds mod 128, bias the quotient positive.
  logic [33:0] day128;
  logic [33:0] u_sum;
  logic [32:0] u1;
  logic [6:0]  lo1;
  logic        err1;

  assign day128 = 34'($signed(seconds[esdc_pkg::SEC_W-1:7]));
  assign u_sum  = day128 + DIV_BIAS;

  always_ff @(posedge clk) begin
    if (en) begin
      u1   <= u_sum[32:0];
      lo1  <= seconds[6:0];
      err1 <= (seconds < esdc_pkg::SEC_MIN) || (seconds > esdc_pkg::SEC_MAX);
    end
  end

  // Stage 2: reciprocal estimate of u / 675.
  logic [64:0] p2;
  logic [22:0] qe2;
  logic [32:0] u2;
  logic [6:0]  lo2;
  logic        err2;

  assign p2 = 65'(u1) * 65'(RECIP_675);

  always_ff @(posedge clk) begin
    if (en) begin
      qe2  <= p2[63:41];
      u2   <= u1;
      lo2  <= lo1;
      err2 <= err1;
    end
  end

  // Stage 3: correct the estimate, form second of day and shifted day number.
  logic [32:0] rem_w;
  logic [10:0] rem_lo;
  logic        rem_big;
  logic [10:0] rem_fix;
  logic [22:0] q_u;
  logic [22:0] z_w;
  logic [16:0] r3;
  logic [21:0] z3;
  logic        err3;

  assign rem_w   = u2 - 33'(33'(qe2) * 33'd675);
  assign rem_lo  = rem_w[10:0];
  assign rem_big = rem_lo >= 11'd675;
  assign rem_fix = rem_big ? rem_lo - 11'd675 : rem_lo;
  assign q_u     = qe2 + 23'(rem_big);
  assign z_w     = q_u - Z_OFFSET;

  always_ff @(posedge clk) begin
    if (en) begin
      r3   <= {rem_fix[9:0], lo2};
      z3   <= z_w[21:0];
      err3 <= err2;
    end
  end

  // Stage 4: minute of day and era estimate.
  logic [35:0] p_m60;
  logic [36:0] p_era;
  logic [10:0] m60_4;
  logic [16:0] r4;
  logic [4:0]  erae4;
  logic [21:0] z4;
  logic        err4;

  assign p_m60 = 36'(r3) * 36'(RECIP_60);
  assign p_era = 37'(z3) * 37'(RECIP_ERA);

  always_ff @(posedge clk) begin
    if (en) begin
      m60_4 <= p_m60[34:24];
      r4    <= r3;
      erae4 <= p_era[36:32];
      z4    <= z3;
      err4  <= err3;
    end
  end

  // Stage 5: second, hour, day of era with its correction.
  logic [16:0] sec_w;
  logic [21:0] p_h;
  logic [21:0] doe_w;
  logic [18:0] doe_lo;
  logic        doe_big;
  logic [18:0] doe_fix;
  logic [5:0]  sec5;
  logic [4:0]  hour5;
  logic [10:0] m60_5;
  logic [17:0] doe5;
  logic [4:0]  era5;
  logic        err5;

  assign sec_w   = r4 - 17'(17'(m60_4) * 17'd60);
  assign p_h     = 22'(m60_4) * 22'(RECIP_60S);
  assign doe_w   = z4 - 22'(22'(erae4) * 22'(esdc_pkg::ERA_DAYS));
  assign doe_lo  = doe_w[18:0];
  assign doe_big = doe_lo >= 19'(esdc_pkg::ERA_DAYS);
  assign doe_fix = doe_big ? doe_lo - 19'(esdc_pkg::ERA_DAYS) : doe_lo;

  always_ff @(posedge clk) begin
    if (en) begin
      sec5  <= sec_w[5:0];
      hour5 <= p_h[20:16];
      m60_5 <= m60_4;
      doe5  <= doe_fix[17:0];
      era5  <= erae4 + 5'(doe_big);
      err5  <= err4;
    end
  end

  // Stage 6: minute; four-year and century corrections of the day of era.
  logic [10:0] min_w;
  logic [31:0] p_n4;
  logic [1:0]  cent_doe;
  tod_t        tod6;
  logic [6:0]  n4_6;
  logic [1:0]  c6;
  logic [17:0] doe6;
  logic [4:0]  era6;

  assign min_w    = m60_5 - 11'(11'(hour5) * 11'd60);
  assign p_n4     = 32'(doe5[17:2]) * 32'(RECIP_365);
  // Last day of the era counts as a fourth century and a 146096-day term: they cancel.
  assign cent_doe = 2'(doe5 >= 18'd36524) + 2'(doe5 >= 18'd73048) + 2'(doe5 >= 18'd109572);

  always_ff @(posedge clk) begin
    if (en) begin
      tod6 <= '{hour: hour5, minute: min_w[5:0], second: sec5, range_error: err5};
      n4_6 <= p_n4[30:24];
      c6   <= cent_doe;
      doe6 <= doe5;
      era6 <= era5;
    end
  end

  // Stage 7: leap-free day count of the era.
  tod_t        tod7;
  logic [17:0] t7;
  logic [17:0] doe7;
  logic [4:0]  era7;

  always_ff @(posedge clk) begin
    if (en) begin
      tod7 <= tod6;
      t7   <= doe6 - 18'(n4_6) + 18'(c6);
      doe7 <= doe6;
      era7 <= era6;
    end
  end

  // Stage 8: year of era.
  logic [33:0] p_y;
  tod_t        tod8;
  logic [8:0]  yoe8;
  logic [17:0] doe8;
  logic [4:0]  era8;

  assign p_y = 34'(t7) * 34'(RECIP_365);

  always_ff @(posedge clk) begin
    if (en) begin
      tod8 <= tod7;
      yoe8 <= p_y[32:24];
      doe8 <= doe7;
      era8 <= era7;
    end
  end

  // Stage 9: day of year from March 1.
  logic [1:0]  cent_yoe;
  logic [17:0] ystart;
  logic [17:0] doy_w;
  tod_t        tod9;
  logic [8:0]  doy9;
  logic [8:0]  yoe9;
  logic [4:0]  era9;

  assign cent_yoe = 2'(yoe8 >= 9'd100) + 2'(yoe8 >= 9'd200) + 2'(yoe8 >= 9'd300);
  assign ystart   = 18'(18'(yoe8) * 18'd365) + 18'(yoe8[8:2]) - 18'(cent_yoe);
  assign doy_w    = doe8 - ystart;

  always_ff @(posedge clk) begin
    if (en) begin
      tod9 <= tod8;
      doy9 <= doy_w[8:0];
      yoe9 <= yoe8;
      era9 <= era8;
    end
  end

  // Stage 10: month index from March.
  logic [10:0] mp_n;
  logic [23:0] p_mp;
  tod_t        tod10;
  logic [3:0]  mp10;
  logic [8:0]  doy10;
  logic [8:0]  yoe10;
  logic [4:0]  era10;

  assign mp_n = 11'(11'(doy9) * 11'd5) + 11'd2;
  assign p_mp = 24'(mp_n) * 24'(RECIP_153);

  always_ff @(posedge clk) begin
    if (en) begin
      tod10 <= tod9;
      mp10  <= p_mp[23:20];
      doy10 <= doy9;
      yoe10 <= yoe9;
      era10 <= era9;
    end
  end

  // Stage 11: day, month, year; drop the date when out of range.
  logic [8:0]                     day_w;
  logic [esdc_pkg::MONTH_W-1:0]   month_w;
  logic                           early;
  logic [esdc_pkg::YEAR_W-1:0]    year_w;

  assign day_w   = doy10 - esdc_pkg::month_start(mp10) + 9'd1;
  assign month_w = (mp10 < 4'd10) ? mp10 + 4'd3 : mp10 - 4'd9;
  assign early   = month_w <= 4'd2;
  assign year_w  = 14'(yoe10) + 14'(14'(era10) * 14'd400) - 14'd400 + 14'(early);

  always_ff @(posedge clk) begin
    if (en) begin
      res.civil.hour   <= tod10.hour;
      res.civil.minute <= tod10.minute;
      res.civil.second <= tod10.second;
      res.range_error  <= tod10.range_error;
      if (tod10.range_error) begin
        res.civil.year  <= '0;
        res.civil.month <= '0;
        res.civil.day   <= '0;
      end else begin
        res.civil.year  <= year_w;
        res.civil.month <= month_w;
        res.civil.day   <= day_w[4:0];
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/esdc_d2s.sv =====
// Civil-date-to-seconds pipeline: closed-form day count, then seconds, padded to match.
`default_nettype none

module esdc_d2s (
  input  logic               clk,
  input  logic               en,
  input  esdc_pkg::civil_t   date,
  output esdc_pkg::d2s_res_t res
);

  localparam logic [11:0] RECIP_25 = 12'd2622;   // exact for x < 650, >> 16
  localparam int unsigned PAD      = esdc_pkg::PIPE_DEPTH - esdc_pkg::D2S_DEPTH;

  typedef struct packed {
    logic [esdc_pkg::HOUR_W-1:0]   hour;
    logic [esdc_pkg::MINUTE_W-1:0] minute;
    logic [esdc_pkg::SECOND_W-1:0] second;
    logic                          range_error;
  } tod_t;

  // Stage 1: year counted from March, shifted by one era; month index.
  logic [14:0] yy1;
  logic [3:0]  mp1;
  logic [4:0]  day1;
  tod_t        tod1;

  always_ff @(posedge clk) begin
    if (en) begin
      yy1  <= 15'(date.year) + 15'd400 - 15'(date.month <= 4'd2);
      mp1  <= (date.month > 4'd2) ? date.month - 4'd3 : date.month + 4'd9;
      day1 <= date.day;
      tod1 <= '{hour: date.hour, minute: date.minute, second: date.second,
                range_error: (date.year > esdc_pkg::YEAR_MAX) || (date.month == 4'd0) ||
                             (date.month > 4'd12)};
    end
  end

  // Stage 2: era by way of (y / 16) / 25; day of year, may be minus one.
  logic [22:0] p_era;
  logic [4:0]  era2;
  logic [14:0] yy2;
  logic [9:0]  doy2;
  tod_t        tod2;

  assign p_era = 23'(yy1[14:4]) * 23'(RECIP_25);

  always_ff @(posedge clk) begin
    if (en) begin
      era2 <= p_era[20:16];
      yy2  <= yy1;
      doy2 <= 10'(esdc_pkg::month_start(mp1)) + 10'(day1) - 10'd1;
      tod2 <= tod1;
    end
  end

  // Stage 3: year of era.
  logic [14:0] yoe_w;
  logic [8:0]  yoe3;
  logic [4:0]  era3;
  logic [9:0]  doy3;
  tod_t        tod3;

  assign yoe_w = yy2 - 15'(15'(era2) * 15'd400);

  always_ff @(posedge clk) begin
    if (en) begin
      yoe3 <= yoe_w[8:0];
      era3 <= era2;
      doy3 <= doy2;
      tod3 <= tod2;
    end
  end

  // Stage 4: day of era.
  logic [1:0]  cent;
  logic [18:0] doe4;
  logic [4:0]  era4;
  tod_t        tod4;

  assign cent = 2'(yoe3 >= 9'd100) + 2'(yoe3 >= 9'd200) + 2'(yoe3 >= 9'd300);

  always_ff @(posedge clk) begin
    if (en) begin
      doe4 <= 19'(19'(yoe3) * 19'd365) + 19'(yoe3[8:2]) - 19'(cent) + 19'($signed(doy3));
      era4 <= era3;
      tod4 <= tod3;
    end
  end

  // Stage 5: signed days since 1970-01-01.
  logic [23:0] days5;
  tod_t        tod5;

  always_ff @(posedge clk) begin
    if (en) begin
      days5 <= 24'(24'(era4) * 24'(esdc_pkg::ERA_DAYS)) + 24'($signed(doe4))
               - 24'(esdc_pkg::DAYS_BIAS);
      tod5  <= tod4;
    end
  end

  // Stage 6: day seconds and time-of-day seconds, added linearly.
  logic [esdc_pkg::SEC_W-1:0] td6;
  logic [16:0]                tsec6;
  logic                       err6;

  always_ff @(posedge clk) begin
    if (en) begin
      td6   <= 39'($signed(days5)) * 39'd86400;
      tsec6 <= 17'(17'(tod5.hour) * 17'd3600) + 17'(17'(tod5.minute) * 17'd60)
               + 17'(tod5.second);
      err6  <= tod5.range_error;
    end
  end

  // Stage 7: final sum; zero on a bad year or month.
  esdc_pkg::d2s_res_t res7;

  always_ff @(posedge clk) begin
    if (en) begin
      res7.seconds     <= err6 ? '0 : td6 + 39'(tsec6);
      res7.range_error <= err6;
    end
  end

  // Delay to the common pipeline depth.
  esdc_pkg::d2s_res_t pad_q [PAD];

  always_ff @(posedge clk) begin
    if (en) begin
      pad_q[0] <= res7;
      for (int i = 1; i < PAD; i++) begin
        pad_q[i] <= pad_q[i-1];
      end
    end
  end

  assign res = pad_q[PAD-1];

endmodule

`default_nettype wire

// ===== rtl/epoch_seconds_datetime_converter.sv =====
// Top level of the epoch seconds <-> proleptic Gregorian date and time converter.
`default_nettype none

// Converts signed Unix epoch seconds to year, month, day, hour, minute and second
// (s_tuser = 0) or the reverse (s_tuser = 1), for the proleptic Gregorian calendar.
// Both directions run side by side in a 12-stage pipeline: eleven stages in the
// conversion units and one output register. One item is taken per cycle while the
// output does not stall. The pipeline advances as a whole
// whenever the output register is empty or being read, so a stall on the output
// holds every stage in place. Seconds outside years 0..9999 set the range flag and
// zero the date (the time of day is still given); a year above 9999 or a month
// outside 1..12 sets the flag and zeroes the seconds. Day-of-month is not checked:
// extra days, hours, minutes and seconds simply add. Fields the chosen direction
// does not produce are zero.
module epoch_seconds_datetime_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // seconds_in[38:0], year_in[52:39], month_in[56:53], day_in[61:57],
  // hour_in[66:62], minute_in[72:67], second_in[78:73], zero pad [79]
  input  logic [79:0] s_tdata,
  // op[0]
  input  logic [0:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // seconds_out[38:0], year_out[52:39], month_out[56:53], day_out[61:57],
  // hour_out[66:62], minute_out[72:67], second_out[78:73], zero pad [79]
  output logic [79:0] m_tdata,
  // range_error[0]
  output logic [0:0]  m_tuser
);

  localparam int unsigned DEPTH = esdc_pkg::PIPE_DEPTH;

  typedef struct packed {
    logic                          pad;
    logic [esdc_pkg::SECOND_W-1:0] second;
    logic [esdc_pkg::MINUTE_W-1:0] minute;
    logic [esdc_pkg::HOUR_W-1:0]   hour;
    logic [esdc_pkg::DAY_W-1:0]    day;
    logic [esdc_pkg::MONTH_W-1:0]  month;
    logic [esdc_pkg::YEAR_W-1:0]   year;
    logic [esdc_pkg::SEC_W-1:0]    seconds;
  } word_t;

  logic               en;
  word_t              in_word;
  word_t              out_word;
  esdc_pkg::civil_t   in_date;
  esdc_pkg::s2d_res_t s2d_res;
  esdc_pkg::d2s_res_t d2s_res;
  logic               vld_q [DEPTH];
  logic               op_q  [DEPTH];

  // Advance the whole pipeline when the output slot is free or being taken.
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  assign in_word = word_t'(s_tdata);
  assign in_date = '{year: in_word.year, month: in_word.month, day: in_word.day,
                     hour: in_word.hour, minute: in_word.minute, second: in_word.second};

  esdc_s2d u_s2d (
    .clk     (clk),
    .en      (en),
    .seconds ($signed(in_word.seconds)),
    .res     (s2d_res)
  );

  esdc_d2s u_d2s (
    .clk  (clk),
    .en   (en),
    .date (in_date),
    .res  (d2s_res)
  );

  // Valid bits and the direction travel beside the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else if (en) begin
      vld_q[0] <= s_tvalid;
      for (int i = 1; i < DEPTH; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op_q[0] <= s_tuser[0];
      for (int i = 1; i < DEPTH; i++) begin
        op_q[i] <= op_q[i-1];
      end
    end
  end

  // Pick the direction's fields; the other direction's fields stay zero.
  always_comb begin
    out_word = '0;
    if (op_q[DEPTH-1]) begin
      out_word.seconds = d2s_res.seconds;
    end else begin
      out_word.year   = s2d_res.civil.year;
      out_word.month  = s2d_res.civil.month;
      out_word.day    = s2d_res.civil.day;
      out_word.hour   = s2d_res.civil.hour;
      out_word.minute = s2d_res.civil.minute;
      out_word.second = s2d_res.civil.second;
    end
  end

  // Output register: hold while the consumer stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= vld_q[DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata    <= out_word;
      m_tuser[0] <= op_q[DEPTH-1] ? d2s_res.range_error : s2d_res.range_error;
    end
  end

endmodule

`default_nettype wire

// ===== bench/epoch_seconds_datetime_converter_test.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the epoch seconds <-> civil date and time converter.
module epoch_seconds_datetime_converter_test;

  localparam int unsigned SEC_W    = esdc_pkg::SEC_W;
  localparam int unsigned YEAR_W   = esdc_pkg::YEAR_W;
  localparam int unsigned MONTH_W  = esdc_pkg::MONTH_W;
  localparam int unsigned DAY_W    = esdc_pkg::DAY_W;
  localparam int unsigned HOUR_W   = esdc_pkg::HOUR_W;
  localparam int unsigned MINUTE_W = esdc_pkg::MINUTE_W;
  localparam int unsigned SECOND_W = esdc_pkg::SECOND_W;

  localparam int unsigned HALF_PERIOD    = 5;
  localparam int unsigned RESET_CYCLES   = 12;
  localparam int unsigned RANDOM_ITEMS   = 925;
  localparam int unsigned IDLE_PERCENT   = 18;
  // Idle-free stretch, counted in accepted items.
  localparam int unsigned QUIET_FIRST    = 300;
  localparam int unsigned QUIET_LAST     = 500;
  // One long output stall, started after this many results.
  localparam int unsigned HOLDOFF_AT     = 650;
  localparam int unsigned HOLDOFF_CYCLES = 200;
  localparam int unsigned STALL_LIMIT    = 2000;
  // Margin after the last result, beyond the latency of the block.
  localparam int unsigned DRAIN_SLACK    = 24;

  localparam logic OP_TO_DATE    = 1'b0;
  localparam logic OP_TO_SECONDS = 1'b1;

  localparam longint DAY_SECONDS     = 64'sd86400;
  localparam longint HOUR_SECONDS    = 64'sd3600;
  localparam longint MINUTE_SECONDS  = 64'sd60;
  localparam longint ERA_DAY_COUNT   = 64'sd146097;
  localparam longint MARCH_ZERO_DAYS = 64'sd719468;
  localparam longint FIRST_SECOND    = -64'sd62167219200;
  localparam longint LAST_SECOND     = 64'sd253402300799;
  localparam longint LAST_YEAR       = 64'sd9999;

  // Field layout shared by s_tdata and m_tdata, lowest bits last.
  typedef struct packed {
    logic                pad;
    logic [SECOND_W-1:0] second;
    logic [MINUTE_W-1:0] minute;
    logic [HOUR_W-1:0]   hour;
    logic [DAY_W-1:0]    day;
    logic [MONTH_W-1:0]  month;
    logic [YEAR_W-1:0]   year;
    logic [SEC_W-1:0]    seconds;
  } datetime_word_t;

  typedef struct {
    logic           op;
    datetime_word_t word;
    bit             wait_drain;  // hold this item until every result is back
  } conversion_t;

  typedef struct {
    datetime_word_t word;
    logic           range_error;
  } conversion_result_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;  // seconds, year, month, day, hour, minute, second, pad
  logic [0:0]  s_tuser = '0;  // op
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;       // seconds, year, month, day, hour, minute, second, pad
  logic [0:0]  m_tuser;       // range_error

  conversion_t        pending_conversions[$];
  conversion_result_t expected_results[$];
  conversion_t        offered;
  conversion_result_t want;
  datetime_word_t     received;
  int unsigned        accepted_items = 0;
  int unsigned        results_seen = 0;
  int unsigned        mismatch_count = 0;
  int unsigned        holdoff_left = 0;
  bit                 holdoff_done = 1'b0;
  int unsigned        stuck_cycles = 0;

  epoch_seconds_datetime_converter u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #HALF_PERIOD clk = ~clk;
  end

  // Expected result of one conversion: floor split of seconds plus the era method,
  // or the closed-form day count in the other direction.
  function automatic conversion_result_t convert(input conversion_t c);
    conversion_result_t r;
    longint s, q, rem, z, era, doe, yoe, doy, mp, dd, mo, yr, hh, mi, ss, t;
    r.word = '0;
    r.range_error = 1'b0;
    if (c.op == OP_TO_DATE) begin
      s = longint'($signed(c.word.seconds));
      q = s / DAY_SECONDS;
      rem = s % DAY_SECONDS;
      if (rem < 0) begin
        rem += DAY_SECONDS;
        q -= 1;
      end
      // Time of day survives even when the date is out of range.
      r.word.hour = HOUR_W'(rem / HOUR_SECONDS);
      r.word.minute = MINUTE_W'((rem % HOUR_SECONDS) / MINUTE_SECONDS);
      r.word.second = SECOND_W'(rem % MINUTE_SECONDS);
      if (s < FIRST_SECOND || s > LAST_SECOND) begin
        r.range_error = 1'b1;
      end else begin
        // Shift by one era so every division sees a non-negative day count.
        z = q + MARCH_ZERO_DAYS + ERA_DAY_COUNT;
        era = z / ERA_DAY_COUNT;
        doe = z - era * ERA_DAY_COUNT;
        yoe = (doe - doe / 1460 + doe / 36524 - doe / (ERA_DAY_COUNT - 1)) / 365;
        doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
        mp = (5 * doy + 2) / 153;
        dd = doy - (153 * mp + 2) / 5 + 1;
        mo = (mp < 10) ? mp + 3 : mp - 9;
        yr = yoe + (era - 1) * 400 + ((mo <= 2) ? 1 : 0);
        r.word.year = YEAR_W'(yr);
        r.word.month = MONTH_W'(mo);
        r.word.day = DAY_W'(dd);
      end
    end else begin
      yr = longint'(c.word.year);
      mo = longint'(c.word.month);
      dd = longint'(c.word.day);
      hh = longint'(c.word.hour);
      mi = longint'(c.word.minute);
      ss = longint'(c.word.second);
      if (yr > LAST_YEAR || mo < 1 || mo > 12) begin
        r.range_error = 1'b1;
      end else begin
        // Count years from March, one era ahead; excess day and time add linearly.
        yr = yr + 400 - ((mo <= 2) ? 1 : 0);
        era = yr / 400;
        yoe = yr - era * 400;
        mp = (mo > 2) ? mo - 3 : mo + 9;
        doy = (153 * mp + 2) / 5 + dd - 1;
        doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        t = ((era - 1) * ERA_DAY_COUNT + doe - MARCH_ZERO_DAYS) * DAY_SECONDS
            + hh * HOUR_SECONDS + mi * MINUTE_SECONDS + ss;
        r.word.seconds = t[SEC_W-1:0];
      end
    end
    return r;
  endfunction

  function automatic longint random_below(input longint span);
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return longint'(raw % span);
  endfunction

  // Fill every field but the pad bit with noise so the unused ones are exercised too.
  function automatic datetime_word_t random_word();
    datetime_word_t w;
    w.pad = 1'b0;
    w.seconds = SEC_W'({$urandom, $urandom});
    w.year = YEAR_W'($urandom);
    w.month = MONTH_W'($urandom);
    w.day = DAY_W'($urandom);
    w.hour = HOUR_W'($urandom);
    w.minute = MINUTE_W'($urandom);
    w.second = SECOND_W'($urandom);
    return w;
  endfunction

  function automatic conversion_t seconds_item(input longint s);
    conversion_t c;
    c.op = OP_TO_DATE;
    c.word = random_word();
    c.word.seconds = SEC_W'(s);
    c.wait_drain = 1'b0;
    return c;
  endfunction

  function automatic conversion_t date_item(input int yr, input int mo, input int dd,
                                            input int hh, input int mi, input int ss);
    conversion_t c;
    c.op = OP_TO_SECONDS;
    c.word = random_word();
    c.word.year = YEAR_W'(yr);
    c.word.month = MONTH_W'(mo);
    c.word.day = DAY_W'(dd);
    c.word.hour = HOUR_W'(hh);
    c.word.minute = MINUTE_W'(mi);
    c.word.second = SECOND_W'(ss);
    return c;
  endfunction

  function automatic bit in_quiet_stretch();
    return accepted_items >= QUIET_FIRST && accepted_items < QUIET_LAST;
  endfunction

  task automatic check_field(input string name, input logic signed [63:0] want_v,
                             input logic signed [63:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      mismatch_count++;
    end
  endtask

  // Sender: record the expectation of each accepted item, then offer the next one
  // unless idling or waiting for the block to drain.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_results.push_back(convert(offered));
        accepted_items++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_conversions.size() != 0
            && !(pending_conversions[0].wait_drain && expected_results.size() != 0)
            && (in_quiet_stretch() || $urandom_range(99) >= IDLE_PERCENT)) begin
          offered = pending_conversions.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= offered.word;
          s_tuser <= offered.op;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each result against the oldest expectation, then pick the
  // next ready, with one long hold-off so the pipeline backs up into the input.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        received = m_tdata;
        if (expected_results.size() == 0) begin
          $error("result arrived with no item outstanding");
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("seconds_out", $signed(want.word.seconds), $signed(received.seconds));
          check_field("year_out", want.word.year, received.year);
          check_field("month_out", want.word.month, received.month);
          check_field("day_out", want.word.day, received.day);
          check_field("hour_out", want.word.hour, received.hour);
          check_field("minute_out", want.word.minute, received.minute);
          check_field("second_out", want.word.second, received.second);
          check_field("range_error", want.range_error, m_tuser[0]);
        end
        results_seen++;
      end
      if (holdoff_left != 0) begin
        holdoff_left--;
        m_tready <= 1'b0;
      end else if (!holdoff_done && results_seen >= HOLDOFF_AT) begin
        holdoff_done = 1'b1;
        holdoff_left = HOLDOFF_CYCLES;
        m_tready <= 1'b0;
      end else begin
        m_tready <= in_quiet_stretch() || $urandom_range(99) >= IDLE_PERCENT;
      end
    end
  end

  // Watchdog: give up when neither side has moved an item for too long.
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  initial begin
    conversion_t c;
    int unsigned pick;
    longint boundary;

    // Seconds to date: epoch, floor division of negatives, day edges, range edges,
    // full-width extremes, leap day and a century year.
    pending_conversions.push_back(seconds_item(0));
    pending_conversions.push_back(seconds_item(-1));
    pending_conversions.push_back(seconds_item(-DAY_SECONDS));
    pending_conversions.push_back(seconds_item(DAY_SECONDS - 1));
    pending_conversions.push_back(seconds_item(FIRST_SECOND));
    pending_conversions.push_back(seconds_item(FIRST_SECOND - 1));
    pending_conversions.push_back(seconds_item(LAST_SECOND));
    pending_conversions.push_back(seconds_item(LAST_SECOND + 1));
    pending_conversions.push_back(seconds_item(-(64'sd1 <<< (SEC_W - 1))));
    pending_conversions.push_back(seconds_item((64'sd1 <<< (SEC_W - 1)) - 1));
    pending_conversions.push_back(seconds_item(64'sd951782400));
    pending_conversions.push_back(seconds_item(64'sd951782400 - DAY_SECONDS));
    pending_conversions.push_back(seconds_item(-64'sd2203891200));
    // Date to seconds: epoch, first and last instants, leap day, day zero, excess
    // day and time, bad year, bad month, all ones and all zeros.
    pending_conversions.push_back(date_item(1970, 1, 1, 0, 0, 0));
    pending_conversions.push_back(date_item(0, 1, 1, 0, 0, 0));
    pending_conversions.push_back(date_item(9999, 12, 31, 23, 59, 59));
    pending_conversions.push_back(date_item(2000, 2, 29, 12, 30, 30));
    pending_conversions.push_back(date_item(2000, 3, 0, 0, 0, 0));
    pending_conversions.push_back(date_item(2023, 2, 31, 0, 0, 0));
    pending_conversions.push_back(date_item(1999, 12, 31, 31, 63, 63));
    pending_conversions.push_back(date_item(10000, 6, 15, 0, 0, 0));
    pending_conversions.push_back(date_item(16383, 15, 31, 31, 63, 63));
    pending_conversions.push_back(date_item(2020, 0, 1, 0, 0, 0));
    pending_conversions.push_back(date_item(2020, 13, 1, 0, 0, 0));
    pending_conversions.push_back(date_item(0, 0, 0, 0, 0, 0));

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        c = seconds_item(FIRST_SECOND + random_below(LAST_SECOND - FIRST_SECOND + 1));
      end else if (pick < 42) begin
        // A few seconds around a range edge or a midnight.
        case ($urandom_range(2))
          0:       boundary = FIRST_SECOND;
          1:       boundary = LAST_SECOND + 1;
          default: boundary = FIRST_SECOND + DAY_SECONDS
                              * random_below((LAST_SECOND - FIRST_SECOND) / DAY_SECONDS);
        endcase
        c = seconds_item(boundary + longint'($urandom_range(7)) - 4);
      end else if (pick < 52) begin
        c = seconds_item(random_below(64'sd1 <<< SEC_W) - (64'sd1 <<< (SEC_W - 1)));
      end else if (pick < 87) begin
        c = date_item($urandom_range(9999), $urandom_range(12, 1), $urandom_range(31),
                      $urandom_range(23), $urandom_range(59), $urandom_range(59));
      end else begin
        // Any field value the widths allow.
        c = date_item($urandom_range(1) ? $urandom_range(9999) : $urandom_range(16383),
                      $urandom_range(15), $urandom_range(31), $urandom_range(31),
                      $urandom_range(63), $urandom_range(63));
      end
      // Pause the sender until the block is empty a couple of times.
      c.wait_drain = (n == 0 || n == 400);
      pending_conversions.push_back(c);
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    while (pending_conversions.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(posedge clk);
    // Let any stray result show up before the verdict.
    repeat (DRAIN_SLACK) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/esdc_pkg.sv
rtl/esdc_s2d.sv
rtl/esdc_d2s.sv
rtl/epoch_seconds_datetime_converter.sv
bench/epoch_seconds_datetime_converter_test.sv
